@@ rtl/sbpe_pkg.sv @@
package sbpe_pkg;

  // Input function codes
  typedef enum logic [2:0] {
    FUNC_PING  = 3'd0,
    FUNC_READ  = 3'd1,
    FUNC_WRITE = 3'd2,
    FUNC_RX    = 3'd3,
    FUNC_TICK  = 3'd4
  } func_e;

  // Reply wait state, one-hot
  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_PING = 3'b010,
    MODE_READ = 3'b100
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_WRONG_ID   = 2'd2,
    ST_TIMEOUT    = 2'd3
  } status_e;

  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [7:0] REG_GOAL    = 8'h2A;
  localparam logic [7:0] REG_PRESENT = 8'h38;
  localparam logic [7:0] OP_PING     = 8'h01;
  localparam logic [7:0] OP_READ     = 8'h02;
  localparam logic [7:0] OP_WRITE    = 8'h03;
  localparam logic [7:0] LEN_PING    = 8'h02;
  localparam logic [7:0] LEN_READ    = 8'h04;
  localparam logic [7:0] LEN_WRITE   = 8'h05;
  localparam logic [7:0] READ_COUNT  = 8'h02;

  // Body byte counts (id .. last parameter)
  localparam logic [3:0] BODY_PING  = 4'd3;
  localparam logic [3:0] BODY_READ  = 4'd5;
  localparam logic [3:0] BODY_WRITE = 4'd6;

  // Reply lengths in bytes
  localparam logic [3:0] REPLY_PING = 4'd6;
  localparam logic [3:0] REPLY_READ = 4'd8;

  localparam logic [3:0] POS_LO_IDX = 4'd5;
  localparam logic [3:0] POS_HI_IDX = 4'd6;
  localparam logic [3:0] ID_IDX     = 4'd2;

  localparam logic [15:0] TIMEOUT_RESET = 16'd20;

  // Finish result of the reply tracker for the item at the head
  typedef struct packed {
    logic        fire;
    status_e     status;
    logic [15:0] position;
  } reply_res_t;

endpackage

@@ rtl/sbpe_frame.sv @@
module sbpe_frame (
  input  sbpe_pkg::func_e func_i,
  input  logic [7:0]      target_id_i,
  input  logic [15:0]     goal_position_i,
  input  logic [3:0]      byte_idx_i,
  output logic [7:0]      tx_byte_o,
  output logic            last_o
);

  logic [7:0] body [6];
  logic [3:0] body_len;
  logic [7:0] csum;
  logic [3:0] pos;

  always_comb begin
    body[0]  = target_id_i;
    body[1]  = sbpe_pkg::LEN_PING;
    body[2]  = sbpe_pkg::OP_PING;
    body[3]  = 8'h00;
    body[4]  = 8'h00;
    body[5]  = 8'h00;
    body_len = sbpe_pkg::BODY_PING;
    unique case (func_i)
      sbpe_pkg::FUNC_READ: begin
        body[1]  = sbpe_pkg::LEN_READ;
        body[2]  = sbpe_pkg::OP_READ;
        body[3]  = sbpe_pkg::REG_PRESENT;
        body[4]  = sbpe_pkg::READ_COUNT;
        body_len = sbpe_pkg::BODY_READ;
      end
      sbpe_pkg::FUNC_WRITE: begin
        body[1]  = sbpe_pkg::LEN_WRITE;
        body[2]  = sbpe_pkg::OP_WRITE;
        body[3]  = sbpe_pkg::REG_GOAL;
        body[4]  = goal_position_i[7:0];
        body[5]  = goal_position_i[15:8];
        body_len = sbpe_pkg::BODY_WRITE;
      end
      default: begin
      end
    endcase
  end

  // Unused body bytes are zero, so the sum may run over all six
  assign csum = ~(body[0] + body[1] + body[2] + body[3] + body[4] + body[5]);
  assign pos  = byte_idx_i - 4'd2;

  always_comb begin
    tx_byte_o = sbpe_pkg::HDR_BYTE;
    last_o    = 1'b0;
    if (byte_idx_i >= 4'd2) begin
      if (pos < body_len) begin
        tx_byte_o = body[pos[2:0]];
      end else begin
        tx_byte_o = csum;
        last_o    = 1'b1;
      end
    end
  end

endmodule

@@ rtl/sbpe_reply.sv @@
module sbpe_reply (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 update_i,
  input  sbpe_pkg::func_e      func_i,
  input  logic [7:0]           target_id_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [15:0]          limit_i,
  output sbpe_pkg::reply_res_t res_o
);

  sbpe_pkg::mode_e   mode_q, mode_d;
  sbpe_pkg::status_e fault_q, fault_d, fault_n;
  logic [3:0]  idx_q, idx_d, idx_n, total;
  logic [7:0]  pid_q, pid_d, lo_q, lo_d, hi_q, hi_d;
  logic [15:0] elapsed_q, elapsed_d;

  always_comb begin
    mode_d    = mode_q;
    fault_d   = fault_q;
    idx_d     = idx_q;
    pid_d     = pid_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    elapsed_d = elapsed_q;
    fault_n   = fault_q;
    idx_n     = idx_q + 4'd1;
    total     = (mode_q == sbpe_pkg::MODE_PING) ? sbpe_pkg::REPLY_PING
                                                : sbpe_pkg::REPLY_READ;
    res_o     = '{fire: 1'b0, status: sbpe_pkg::ST_OK, position: 16'h0000};
    unique case (func_i) inside
      sbpe_pkg::FUNC_PING, sbpe_pkg::FUNC_READ, sbpe_pkg::FUNC_WRITE: begin
        pid_d     = target_id_i;
        idx_d     = 4'd0;
        fault_d   = sbpe_pkg::ST_OK;
        elapsed_d = 16'h0000;
        if (func_i == sbpe_pkg::FUNC_PING) begin
          mode_d = sbpe_pkg::MODE_PING;
        end else if (func_i == sbpe_pkg::FUNC_READ) begin
          mode_d = sbpe_pkg::MODE_READ;
        end else begin
          mode_d = sbpe_pkg::MODE_IDLE;
        end
      end
      sbpe_pkg::FUNC_RX: begin
        if (mode_q != sbpe_pkg::MODE_IDLE) begin
          // first fault seen wins
          if ((idx_q == 4'd0 || idx_q == 4'd1) && rx_byte_i != sbpe_pkg::HDR_BYTE &&
              fault_q == sbpe_pkg::ST_OK) begin
            fault_n = sbpe_pkg::ST_BAD_HEADER;
          end
          if (idx_q == sbpe_pkg::ID_IDX && rx_byte_i != pid_q &&
              fault_q == sbpe_pkg::ST_OK) begin
            fault_n = sbpe_pkg::ST_WRONG_ID;
          end
          if (idx_q == sbpe_pkg::POS_LO_IDX) lo_d = rx_byte_i;
          if (idx_q == sbpe_pkg::POS_HI_IDX) hi_d = rx_byte_i;
          fault_d = fault_n;
          if (idx_n >= total) begin
            res_o.fire   = 1'b1;
            res_o.status = fault_n;
            if (fault_n == sbpe_pkg::ST_OK && mode_q == sbpe_pkg::MODE_READ) begin
              res_o.position = {hi_q, lo_q};
            end
            mode_d = sbpe_pkg::MODE_IDLE;
            idx_d  = 4'd0;
          end else begin
            idx_d = idx_n;
          end
        end
      end
      sbpe_pkg::FUNC_TICK: begin
        if (mode_q != sbpe_pkg::MODE_IDLE) begin
          if (elapsed_q >= limit_i) begin
            res_o.fire   = 1'b1;
            res_o.status = sbpe_pkg::ST_TIMEOUT;
            mode_d       = sbpe_pkg::MODE_IDLE;
            idx_d        = 4'd0;
          end else begin
            elapsed_d = elapsed_q + 16'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= sbpe_pkg::MODE_IDLE;
      fault_q   <= sbpe_pkg::ST_OK;
      idx_q     <= 4'd0;
      pid_q     <= 8'h00;
      lo_q      <= 8'h00;
      hi_q      <= 8'h00;
      elapsed_q <= 16'h0000;
    end else if (update_i) begin
      mode_q    <= mode_d;
      fault_q   <= fault_d;
      idx_q     <= idx_d;
      pid_q     <= pid_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

@@ rtl/servo_bus_packet_engine.sv @@
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i/in_stall_o    func, target_id, goal_position, rx_byte
// out       output     out_valid_o/out_stall_i  kind, tx_byte, last, status, present_position
// cfg       input      cfg_we_i                 cfg_wdata_i (reply_timeout_ticks)
//
// A byte or tick item gives at most one result item.
// A command item gives one transmit item per packet byte (6 ping, 8 read, 9 write),
// one per cycle unless the output stalls, through the single output register.
// Reset clears the head and output valid flags and the reply state;
// the timeout limit resets to 20 ticks.
// An output stall holds the result register and, through it, any head item
// with a result to load; the input is stalled only while the head item cannot leave.
module servo_bus_packet_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic [7:0]         target_id_i,
  input  logic [15:0]        goal_position_i,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               kind_o,
  output logic [7:0]         tx_byte_o,
  output logic               last_o,
  output logic [1:0]         status_o,
  output logic signed [15:0] present_position_o,
  input  logic               cfg_we_i,
  input  logic [15:0]        cfg_wdata_i
);

  // Head register: the item under work
  logic        head_valid_q, head_valid_d;
  logic [2:0]  head_func_q;
  logic [7:0]  head_id_q;
  logic [15:0] head_goal_q;
  logic [7:0]  head_rx_q;
  sbpe_pkg::func_e head_func;

  logic [3:0]  byte_idx_q, byte_idx_d;
  logic [15:0] limit_q;

  logic        out_valid_q, out_valid_d;
  logic        kind_q;
  logic [7:0]  tx_q;
  logic        last_q;
  logic [1:0]  status_q;
  logic [15:0] pos_q;

  logic        in_accept, load_ok, is_cmd, emit, consume;
  logic [7:0]  frame_byte;
  logic        frame_last;
  sbpe_pkg::reply_res_t res;

  assign head_func = sbpe_pkg::func_e'(head_func_q);
  assign is_cmd    = (head_func == sbpe_pkg::FUNC_PING) ||
                     (head_func == sbpe_pkg::FUNC_READ) ||
                     (head_func == sbpe_pkg::FUNC_WRITE);

  sbpe_frame u_frame (
    .func_i          (head_func),
    .target_id_i     (head_id_q),
    .goal_position_i (head_goal_q),
    .byte_idx_i      (byte_idx_q),
    .tx_byte_o       (frame_byte),
    .last_o          (frame_last)
  );

  sbpe_reply u_reply (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .update_i    (consume),
    .func_i      (head_func),
    .target_id_i (head_id_q),
    .rx_byte_i   (head_rx_q),
    .limit_i     (limit_q),
    .res_o       (res)
  );

  // The result register can take a new item when empty or being drained
  assign load_ok = !out_valid_q || !out_stall_i;

  assign emit    = head_valid_q && load_ok && (is_cmd || res.fire);

  // Drop the head once its last result is loaded, or at once if it gives none
  assign consume = head_valid_q &&
                   (is_cmd ? (load_ok && frame_last) : (!res.fire || load_ok));

  assign in_stall_o = head_valid_q && !consume;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    head_valid_d = head_valid_q;
    if (in_accept) begin
      head_valid_d = 1'b1;
    end else if (consume) begin
      head_valid_d = 1'b0;
    end
  end

  // Advance the packet byte counter with each byte loaded
  always_comb begin
    byte_idx_d = byte_idx_q;
    if (head_valid_q && is_cmd && load_ok) begin
      byte_idx_d = frame_last ? 4'd0 : byte_idx_q + 4'd1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      byte_idx_q   <= 4'd0;
      out_valid_q  <= 1'b0;
      limit_q      <= sbpe_pkg::TIMEOUT_RESET;
    end else begin
      head_valid_q <= head_valid_d;
      byte_idx_q   <= byte_idx_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      head_func_q <= func_i;
      head_id_q   <= target_id_i;
      head_goal_q <= goal_position_i;
      head_rx_q   <= rx_byte_i;
    end
    if (emit) begin
      if (is_cmd) begin
        kind_q   <= 1'b0;
        tx_q     <= frame_byte;
        last_q   <= frame_last;
        status_q <= sbpe_pkg::ST_OK;
        pos_q    <= 16'h0000;
      end else begin
        kind_q   <= 1'b1;
        tx_q     <= 8'h00;
        last_q   <= 1'b0;
        status_q <= res.status;
        pos_q    <= res.position;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = kind_q;
  assign tx_byte_o          = tx_q;
  assign last_o             = last_q;
  assign status_o           = status_q;
  assign present_position_o = pos_q;

  // A marked last byte is always a transmit item
  a_last_is_tx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> !kind_o)
    else $error("last set on a finish item");

  // A failed transaction carries no position
  a_fail_no_pos : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o && status_o != sbpe_pkg::ST_OK |-> present_position_o == 16'h0000)
    else $error("position on a failed transaction");

  // Mid-packet the head must hold a command
  a_idx_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_idx_q != 4'd0 |-> head_valid_q && is_cmd)
    else $error("byte counter running without a command");

  // A head that is not consumed stays in place
  a_head_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_q && !consume |=> head_valid_q && $stable(head_func_q) && $stable(head_id_q))
    else $error("head item lost or changed");

endmodule
